// File: hw/rtl/weighted_priority_record_order_assert.svh
// Assertion macros for the record orderer.
`ifndef WEIGHTED_PRIORITY_RECORD_ORDER_ASSERT_SVH
`define WEIGHTED_PRIORITY_RECORD_ORDER_ASSERT_SVH

// Assert that a condition implies a consequence in the same cycle.
`define WPRO_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Assert that a condition implies a consequence in the next cycle.
`define WPRO_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/wpro_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wpro_pkg;

  localparam int unsigned MaxRecordsDef = 64;
  localparam int unsigned PrioW = 16;
  localparam int unsigned WeightW = 16;
  localparam int unsigned TagW = 8;
  localparam int unsigned RandW = 31;
  // Sum of up to 256 weights of 16 bits.
  localparam int unsigned SumW = 24;

  typedef enum logic [1:0] {
    OpLoad  = 2'd0,
    OpDraw  = 2'd1,
    OpClear = 2'd2,
    OpNone  = 2'd3
  } op_e;

  // Draw sequencer states.
  typedef enum logic [2:0] {
    StIdle, StMin, StSum, StMod, StScan0, StScan1, StRest, StOut
  } st_e;

  // Entry of the record memory: priority, weight and tag.
  typedef struct packed {
    logic [PrioW-1:0]   prio;
    logic [WeightW-1:0] weight;
    logic [TagW-1:0]    tag;
  } rec_t;

  // Request and reply between sequencer and the modulo unit.
  typedef struct packed {
    logic            start;
    logic [RandW-1:0] dividend;
    logic [SumW:0]   divisor;
  } mod_req_t;

  typedef struct packed {
    logic            done;
    logic [SumW:0]   rem;
  } mod_rsp_t;

endpackage
`default_nettype wire

// File: hw/rtl/wpro_mod.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring remainder unit, one dividend bit per cycle.
module wpro_mod (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire wpro_pkg::mod_req_t req_i,
  output wpro_pkg::mod_rsp_t     rsp_o
);

  localparam int unsigned RW = wpro_pkg::SumW + 1;
  localparam int unsigned CntW = $clog2(wpro_pkg::RandW + 1);

  logic [RW-1:0]              rem_q, rem_d;
  logic [RW-1:0]              div_q;
  logic [wpro_pkg::RandW-1:0] sh_q;
  logic [CntW-1:0]            cnt_q;
  logic                       busy_q, done_q;
  logic [RW:0]                trial;

  // Shift in the next dividend bit and subtract when it fits.
  always_comb begin
    trial = {rem_q, sh_q[wpro_pkg::RandW-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = RW'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[RW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(wpro_pkg::RandW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      div_q <= req_i.divisor;
      sh_q  <= req_i.dividend;
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= {sh_q[wpro_pkg::RandW-2:0], 1'b0};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule
`default_nettype wire

// File: hw/rtl/wpro_store.sv
`timescale 1ns / 1ps
`default_nettype none
// Record memory with registered read, plus taken marks in flip-flops.
module wpro_store #(
  parameter int unsigned MaxRecords = wpro_pkg::MaxRecordsDef,
  localparam int unsigned AW = $clog2(MaxRecords)
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           we_i,
  input  wire logic [AW-1:0]  waddr_i,
  input  wire wpro_pkg::rec_t wdata_i,
  input  wire logic [AW-1:0]  raddr_i,
  output wpro_pkg::rec_t      rdata_o,
  input  wire logic           clr_i,
  input  wire logic           mark_i,
  input  wire logic           unmark_i,
  input  wire logic [AW-1:0]  maddr_i,
  output logic                rtaken_o
);

  wpro_pkg::rec_t mem_q [MaxRecords];
  logic [MaxRecords-1:0] taken_q;

  // Memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

  // Taken marks; the read is registered beside the memory data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q  <= '0;
      rtaken_o <= 1'b0;
    end else begin
      rtaken_o <= taken_q[raddr_i];
      if (clr_i) begin
        taken_q <= '0;
      end else if (mark_i) begin
        taken_q[maddr_i] <= 1'b1;
      end else if (unmark_i) begin
        taken_q[maddr_i] <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/weighted_priority_record_order.sv
`timescale 1ns / 1ps
`default_nettype none
// Orders stored service records by priority and weighted random choice. Loads, clears and
// unused codes are accepted with no result. A draw makes up to five passes over the N
// loaded records through the registered memory read port (minimum priority, weight sum,
// zero-weight scan, weighted scan, records left), runs the bit-serial remainder unit (start,
// 31 dividend bits, done) between the weight sum and the scans, and then fetches the pick.
// A draw that finds no record left skips the later passes and answers with nothing left.
// The result waits in an output register and holds off the input until it is taken.
module weighted_priority_record_order #(
  parameter int unsigned MaxRecords = wpro_pkg::MaxRecordsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [15:0] record_priority_i,
  input  wire logic [15:0] record_weight_i,
  input  wire logic [7:0]  record_tag_i,
  input  wire logic [30:0] random_word_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       chosen_tag_o,
  output logic [15:0]      chosen_priority_o,
  output logic [15:0]      chosen_weight_o,
  output logic             last_of_run_o,
  output logic             nothing_left_o
);

`include "weighted_priority_record_order_assert.svh"

  localparam int unsigned AW = $clog2(MaxRecords);
  localparam int unsigned CW = $clog2(MaxRecords + 1);
  localparam int unsigned SW = wpro_pkg::SumW;

  wpro_pkg::st_e st_q, st_d;
  logic [CW-1:0] loaded_q, idx_q;
  logic [AW-1:0] pick_q;
  logic          any_q, found_q, rest_q;
  logic [15:0]   minp_q;
  logic [SW-1:0] sum_q, run_q, thr_q;
  logic [30:0]   rnd_q;
  logic          ovalid_q;
  wpro_pkg::rec_t rd;
  logic          rtaken;
  wpro_pkg::mod_req_t mreq;
  wpro_pkg::mod_rsp_t mrsp;

  logic accept, do_load, pass_go, at_end, open_now;
  logic [CW-1:0] idx_rd;
  logic [SW-1:0] run_nx;

  assign accept  = in_valid_i && in_ready_o;
  assign do_load = accept && (operation_i == wpro_pkg::OpLoad) &&
                   (loaded_q < CW'(MaxRecords));
  assign pass_go = (st_q == wpro_pkg::StMin) || (st_q == wpro_pkg::StSum) ||
                   (st_q == wpro_pkg::StScan0) || (st_q == wpro_pkg::StScan1) ||
                   (st_q == wpro_pkg::StRest);
  // idx_q is the address in flight; data for idx_q-1 is valid when idx_q > 0.
  assign idx_rd  = idx_q - 1'b1;
  assign at_end  = (idx_q == loaded_q) || (idx_q == CW'(MaxRecords));
  assign open_now = (idx_q != '0) && !rtaken;
  assign run_nx  = run_q + SW'(rd.weight);

  wpro_store #(.MaxRecords(MaxRecords)) u_store (
    .clk_i, .rst_ni,
    .we_i     (do_load),
    .waddr_i  (loaded_q[AW-1:0]),
    .wdata_i  ('{prio: record_priority_i, weight: record_weight_i, tag: record_tag_i}),
    .raddr_i  (st_d == wpro_pkg::StOut ? pick_q : idx_q[AW-1:0]),
    .rdata_o  (rd),
    .clr_i    (accept && (operation_i == wpro_pkg::OpClear)),
    .mark_i   ((st_q == wpro_pkg::StRest) && (idx_q == '0)),
    .unmark_i (do_load),
    .maddr_i  (do_load ? loaded_q[AW-1:0] : pick_q),
    .rtaken_o (rtaken)
  );

  // The remainder starts once, on the first cycle of StMod, when the sum is complete.
  assign mreq.start    = (st_q == wpro_pkg::StMod) && (idx_q == '0);
  assign mreq.dividend = rnd_q;
  assign mreq.divisor  = {1'b0, sum_q} + 1'b1;

  wpro_mod u_mod (.clk_i, .rst_ni, .req_i(mreq), .rsp_o(mrsp));

  assign in_ready_o = (st_q == wpro_pkg::StIdle) && !ovalid_q;

  // Next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      wpro_pkg::StIdle:  if (accept && operation_i == wpro_pkg::OpDraw) st_d = wpro_pkg::StMin;
      wpro_pkg::StMin:   if (at_end && idx_q != '0 || loaded_q == '0) st_d = wpro_pkg::StSum;
      wpro_pkg::StSum:   if (!any_q) st_d = wpro_pkg::StOut;
                         else if (at_end) st_d = wpro_pkg::StMod;
      wpro_pkg::StMod:   if (mrsp.done) st_d = wpro_pkg::StScan0;
      wpro_pkg::StScan0: if (found_q) st_d = wpro_pkg::StRest;
                         else if (at_end && idx_q != '0 &&
                                  !(open_now && rd.prio == minp_q && rd.weight == '0 &&
                                    run_q >= thr_q)) st_d = wpro_pkg::StScan1;
      wpro_pkg::StScan1: if (found_q) st_d = wpro_pkg::StRest;
      wpro_pkg::StRest:  if (at_end && idx_q != '0) st_d = wpro_pkg::StOut;
      wpro_pkg::StOut:   st_d = wpro_pkg::StIdle;
      default:           st_d = wpro_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= wpro_pkg::StIdle;
      loaded_q <= '0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (do_load) loaded_q <= loaded_q + 1'b1;
      if (accept && operation_i == wpro_pkg::OpClear) loaded_q <= '0;
      if (st_d != st_q) begin
        idx_q <= '0;
      end else if (pass_go && !at_end) begin
        idx_q <= idx_q + 1'b1;
      end else if (st_q == wpro_pkg::StMod && idx_q == '0) begin
        idx_q <= CW'(1);
      end else if (pass_go && st_q == wpro_pkg::StScan1 && at_end) begin
        idx_q <= idx_q;
      end
      if (st_q == wpro_pkg::StOut) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
    end
  end

  // Per-pass datapath on the registered memory read.
  always_ff @(posedge clk_i) begin
    case (st_q)
      wpro_pkg::StIdle: begin
        any_q <= 1'b0; found_q <= 1'b0; rest_q <= 1'b0;
        sum_q <= '0; run_q <= '0; rnd_q <= random_word_i;
      end
      wpro_pkg::StMin: if (open_now && (!any_q || rd.prio < minp_q)) begin
        minp_q <= rd.prio; any_q <= 1'b1;
      end
      wpro_pkg::StSum: if (open_now && rd.prio == minp_q) sum_q <= sum_q + SW'(rd.weight);
      wpro_pkg::StMod: if (mrsp.done) thr_q <= mrsp.rem[SW-1:0];
      wpro_pkg::StScan0, wpro_pkg::StScan1: if (!found_q && open_now && rd.prio == minp_q &&
                            ((st_q == wpro_pkg::StScan0) == (rd.weight == '0))) begin
        run_q <= run_nx;
        if (run_nx >= thr_q) begin
          found_q <= 1'b1; pick_q <= idx_rd[AW-1:0];
        end
      end
      wpro_pkg::StRest: if (open_now && idx_rd[AW-1:0] != pick_q) rest_q <= 1'b1;
      default: ;
    endcase
  end

  // Result register; the pick is addressed on the way into StOut, so its data is here.
  always_ff @(posedge clk_i) begin
    if (st_q == wpro_pkg::StOut) begin
      chosen_tag_o      <= any_q ? rd.tag : '0;
      chosen_priority_o <= any_q ? rd.prio : '0;
      chosen_weight_o   <= any_q ? rd.weight : '0;
      last_of_run_o     <= any_q && !rest_q;
      nothing_left_o    <= !any_q;
    end
  end

  assign out_valid_o = ovalid_q;

  `WPRO_ASSERT_IMPL(a_ready_idle, clk_i, rst_ni, in_ready_o, st_q == wpro_pkg::StIdle,
                    "ready outside idle")
  `WPRO_ASSERT_NEXT(a_out_after, clk_i, rst_ni, st_q == wpro_pkg::StOut, out_valid_o,
                    "result not presented")
  `WPRO_ASSERT_IMPL(a_cnt_bound, clk_i, rst_ni, 1'b1, loaded_q <= CW'(MaxRecords),
                    "loaded count beyond capacity")

endmodule
`default_nettype wire
